// ----- rtl/core/hacs_pkg.sv -----
// ----------------------------------------------------------------------------
// hacs_pkg
// Types, codes and reset values shared by the hatch actuator sequencer.
// ----------------------------------------------------------------------------
package hacs_pkg;

  localparam int CURRENT_BITS_DEF = 16;
  localparam int TIMER_BITS_DEF   = 16;

  localparam int OVER_LIMIT_RST   = 5000;
  localparam int UNDER_LIMIT_RST  = 200;
  localparam int SETTLE_TICKS_RST = 100;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_OPEN   = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_STOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_UNDET      = 3'd0,
    ST_OPENING    = 3'd1,
    ST_OPENED     = 3'd2,
    ST_CLOSING    = 3'd3,
    ST_CLOSED     = 3'd4,
    ST_OPEN_STOP  = 3'd5,
    ST_CLOSE_STOP = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    STG_HORIZ = 2'd0,
    STG_HATCH = 2'd1,
    STG_BOTH  = 2'd2
  } stage_t;

  typedef enum logic [1:0] {
    CFG_OVER_LIMIT   = 2'd0,
    CFG_UNDER_LIMIT  = 2'd1,
    CFG_SETTLE_TICKS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic up;
    logic down;
    logic hatch;
  } drive_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] current_ma;
  } in_beat_t;

  typedef struct packed {
    logic    drive_up;
    logic    drive_down;
    logic    hatch_enable;
    status_t move_status;
    stage_t  active_stage;
    logic    in_motion;
  } out_beat_t;

endpackage

// ----- rtl/core/hacs_cfg.sv -----
// ----------------------------------------------------------------------------
// hacs_cfg
// Configuration registers: current limits and settle time.
// ----------------------------------------------------------------------------
module hacs_cfg #(
  parameter int CURRENT_BITS = hacs_pkg::CURRENT_BITS_DEF,
  parameter int TIMER_BITS   = hacs_pkg::TIMER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  hacs_pkg::cfg_idx_t      wr_index,
  input  logic [15:0]             wr_data,
  output logic [CURRENT_BITS-1:0] over_limit,
  output logic [CURRENT_BITS-1:0] under_limit,
  output logic [TIMER_BITS-1:0]   settle_ticks
);
  import hacs_pkg::*;

  logic [CURRENT_BITS-1:0] over_r,  over_nxt;
  logic [CURRENT_BITS-1:0] under_r, under_nxt;
  logic [TIMER_BITS-1:0]   ticks_r, ticks_nxt;

  always_comb begin
    over_nxt  = over_r;
    under_nxt = under_r;
    ticks_nxt = ticks_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_OVER_LIMIT:   over_nxt  = CURRENT_BITS'(wr_data);
        CFG_UNDER_LIMIT:  under_nxt = CURRENT_BITS'(wr_data);
        CFG_SETTLE_TICKS: ticks_nxt = TIMER_BITS'(wr_data);
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_r  <= CURRENT_BITS'(OVER_LIMIT_RST);
      under_r <= CURRENT_BITS'(UNDER_LIMIT_RST);
      ticks_r <= TIMER_BITS'(SETTLE_TICKS_RST);
    end else begin
      over_r  <= over_nxt;
      under_r <= under_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  assign over_limit   = over_r;
  assign under_limit  = under_r;
  assign settle_ticks = ticks_r;

endmodule

// ----- rtl/core/hacs_core.sv -----
// ----------------------------------------------------------------------------
// hacs_core
// Move state, stage, settle timer and drive registers, with the
// combinational transition logic for one command or current sample.
// ----------------------------------------------------------------------------
module hacs_core #(
  parameter int CURRENT_BITS = hacs_pkg::CURRENT_BITS_DEF,
  parameter int TIMER_BITS   = hacs_pkg::TIMER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  hacs_pkg::in_beat_t      beat,
  input  logic [CURRENT_BITS-1:0] over_limit,
  input  logic [CURRENT_BITS-1:0] under_limit,
  input  logic [TIMER_BITS-1:0]   settle_ticks,
  output hacs_pkg::out_beat_t     result
);
  import hacs_pkg::*;

  status_t                 status_r, status_nxt;
  stage_t                  stage_r,  stage_nxt;
  logic [TIMER_BITS-1:0]   count_r,  count_nxt;
  drive_t                  drive_r,  drive_nxt;

  logic [CURRENT_BITS-1:0] cur;
  logic                    expired;
  logic                    idle;
  logic                    moving;

  assign cur     = CURRENT_BITS'(beat.current_ma);
  assign expired = (count_r == '0);
  assign moving  = (status_r == ST_OPENING) || (status_r == ST_CLOSING);
  assign idle    = status_r inside {ST_OPENED, ST_CLOSED, ST_OPEN_STOP, ST_CLOSE_STOP};

  always_comb begin
    status_nxt = status_r;
    stage_nxt  = stage_r;
    count_nxt  = count_r;
    drive_nxt  = drive_r;
    unique case (beat.op)
      OP_SAMPLE: begin
        // judge with the count held before this tick, then decrement
        count_nxt = expired ? '0 : count_r - 1'b1;
        if (!idle && expired) begin
          if (cur > over_limit) begin
            if (status_r == ST_CLOSING) status_nxt = ST_CLOSE_STOP;
            else if (status_r == ST_OPENING) status_nxt = ST_OPEN_STOP;
            drive_nxt = '0;
          end else if (cur < under_limit && moving) begin
            if (stage_r == STG_HORIZ) begin
              // hand over to the hatch stage and restart settling
              count_nxt       = settle_ticks;
              drive_nxt.hatch = 1'b1;
              stage_nxt       = STG_HATCH;
            end else begin
              drive_nxt  = '0;
              status_nxt = (status_r == ST_CLOSING) ? ST_CLOSED : ST_OPENED;
            end
          end
        end
      end
      OP_OPEN: begin
        if (status_r != ST_OPENING && status_r != ST_OPENED) begin
          count_nxt  = settle_ticks;
          drive_nxt  = '{up: 1'b1, down: 1'b0, hatch: 1'b1};
          status_nxt = ST_OPENING;
          stage_nxt  = STG_BOTH;
        end
      end
      OP_CLOSE: begin
        if (status_r != ST_CLOSING && status_r != ST_CLOSED) begin
          count_nxt  = settle_ticks;
          drive_nxt  = '{up: 1'b0, down: 1'b1, hatch: 1'b0};
          status_nxt = ST_CLOSING;
          stage_nxt  = STG_HORIZ;
        end
      end
      OP_STOP: begin
        if (status_r == ST_CLOSING) status_nxt = ST_CLOSE_STOP;
        else if (status_r == ST_OPENING) status_nxt = ST_OPEN_STOP;
        drive_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_UNDET;
      stage_r  <= STG_HORIZ;
      count_r  <= '0;
      drive_r  <= '0;
    end else if (step_en) begin
      status_r <= status_nxt;
      stage_r  <= stage_nxt;
      count_r  <= count_nxt;
      drive_r  <= drive_nxt;
    end
  end

  always_comb begin
    result.drive_up     = drive_nxt.up;
    result.drive_down   = drive_nxt.down;
    result.hatch_enable = drive_nxt.hatch;
    result.move_status  = status_nxt;
    result.active_stage = stage_nxt;
    result.in_motion    = (status_nxt == ST_OPENING) || (status_nxt == ST_CLOSING);
  end

endmodule

// ----- rtl/core/hatch_actuator_current_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// hatch_actuator_current_sequencer_unit
// Two-stage hatch actuator sequencer driven by commands and current samples.
//
//   channel | ports                                   | dir | beat
//   --------+-----------------------------------------+-----+-----------------
//   in      | in_valid, in_stall, in_data             | in  | op, current_ma
//   out     | out_valid, out_stall, out_data          | out | drives, status
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_wdata | in | limits, ticks
//
// One beat per cycle sustained while out_stall is low; a beat passes through the
// input register, then the transition logic into the result register. The only
// loop is the registered state update in hacs_core. Reset is synchronous, active
// low, and clears move state, timer, drives and the limits to their defaults.
// A stalled result holds in the output register; an empty input register still
// takes one more beat before in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
module hatch_actuator_current_sequencer_unit #(
  parameter int CURRENT_BITS = hacs_pkg::CURRENT_BITS_DEF,
  parameter int TIMER_BITS   = hacs_pkg::TIMER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hacs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hacs_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  hacs_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import hacs_pkg::*;

  logic                    in_valid_r, in_valid_nxt;
  in_beat_t                in_beat_r;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_beat_r;
  out_beat_t               result;
  logic                    in_take;
  logic                    out_load;
  logic                    advance;
  logic [CURRENT_BITS-1:0] over_limit;
  logic [CURRENT_BITS-1:0] under_limit;
  logic [TIMER_BITS-1:0]   settle_ticks;

  assign cfg_ready = 1'b1;

  hacs_cfg #(
    .CURRENT_BITS(CURRENT_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (cfg_valid && cfg_ready),
    .wr_index    (cfg_index),
    .wr_data     (cfg_wdata),
    .over_limit  (over_limit),
    .under_limit (under_limit),
    .settle_ticks(settle_ticks)
  );

  // result register frees up when empty or being drained
  assign out_load = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_load;
  assign in_stall = in_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  hacs_core #(
    .CURRENT_BITS(CURRENT_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .beat        (in_beat_r),
    .over_limit  (over_limit),
    .under_limit (under_limit),
    .settle_ticks(settle_ticks),
    .result      (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
    out_valid_nxt = out_load ? advance : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_beat_r <= in_data;
    if (advance) out_beat_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

  // a beat that leaves the input register lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("advanced beat did not reach the result register");

  // input register is never stalled while the result side can load
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // in_motion follows the reported status
  a_motion_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.in_motion ==
      ((out_data.move_status == ST_OPENING) || (out_data.move_status == ST_CLOSING))))
    else $error("in_motion disagrees with move_status");

  // a finished or stopped move leaves every drive off
  a_rest_drives_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.move_status == ST_OPENED ||
                   out_data.move_status == ST_CLOSED ||
                   out_data.move_status == ST_OPEN_STOP ||
                   out_data.move_status == ST_CLOSE_STOP))
    |-> !(out_data.drive_up || out_data.drive_down || out_data.hatch_enable))
    else $error("drive active while the hatch is at rest");

endmodule
